FILE: design/mmc_pkg.sv
// Shared types and constants for the magnetometer min/max calibrator.
// Holds the payload structs for the input and result words and the register indexes.
// No dependencies.
`default_nettype none

package mmc_pkg;

    localparam int unsigned NUM_AXES = 3;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_READ_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_WINDOW   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_APPLY_OFFSET = 2'd2;

    localparam logic [23:0] READ_PERIOD_RESET = 24'd100000;
    localparam logic [30:0] CAL_WINDOW_RESET  = 31'd30000000;

    typedef struct packed {
        logic [31:0]        now_us;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
        logic               start_cal;
    } in_t;

    typedef struct packed {
        logic               read_taken;
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
        logic signed [15:0] field_z;
        logic               cal_running;
        logic               cal_done;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_z;
    } out_t;

endpackage

`default_nettype wire

FILE: design/magnetometer_minmax_calibrator.sv
// Magnetometer min/max hard-iron calibrator, top level.
// Uses mmc_pkg for payload structs, register indexes and reset values.
//
// Usage:
//   Input words (in_valid/in_ready, in_data) carry a microsecond time stamp,
//   one three-axis sample and a calibration request. Each input word gives
//   exactly one result word (out_valid/out_ready, out_data).
//   The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   read period, window length and the offset enable; it is always ready and
//   is meant to be written while no word is in flight.
//   The result is registered and appears in the cycle after the input is accepted.
//   Throughput: one word per cycle while out_ready is high; the whole
//   update (time compare, offset subtract, min/max compare, halving) is one
//   combinational pass from the port to the result register.
//   Stall: while a result waits on out_ready, in_ready drops; it rises again
//   in the cycle the result is taken, so a new word enters in that cycle.
//   Reset: offsets, timing state and the window clear; config registers load
//   their defaults (100000 us period, 30000000 us window, offsets applied).
`default_nettype none

module magnetometer_minmax_calibrator #(
    parameter int unsigned AXIS_COUNT = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire mmc_pkg::in_t                     in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output mmc_pkg::out_t                         out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // config registers
    logic [23:0] read_period_reg;
    logic [30:0] cal_window_reg;
    logic        apply_offset_reg;

    // calibration state
    logic [31:0]        next_read_reg,    next_read_next;
    logic [31:0]        window_start_reg, window_start_next;
    logic               window_active_reg, window_active_next;
    logic               pending_reg,      pending_next;
    logic signed [15:0] offset_reg [AXIS_COUNT];
    logic signed [15:0] offset_next [AXIS_COUNT];
    logic signed [15:0] min_reg [AXIS_COUNT];
    logic signed [15:0] min_next [AXIS_COUNT];
    logic signed [15:0] max_reg [AXIS_COUNT];
    logic signed [15:0] max_next [AXIS_COUNT];

    logic          out_valid_reg;
    mmc_pkg::out_t out_reg, out_next;

    logic in_fire;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        logic signed [15:0] raw      [mmc_pkg::NUM_AXES];
        logic signed [15:0] field    [mmc_pkg::NUM_AXES];
        logic signed [15:0] off_show [mmc_pkg::NUM_AXES];
        logic signed [15:0] off_cur;
        logic signed [15:0] lo_cur;
        logic signed [15:0] hi_cur;
        logic signed [16:0] sum;
        logic [31:0]        since;
        logic [31:0]        elapsed;
        logic               taken;
        logic               seed;
        logic               running;
        logic               done;

        raw[0] = in_data.sample_x;
        raw[1] = in_data.sample_y;
        raw[2] = in_data.sample_z;

        pending_next       = pending_reg || in_data.start_cal;
        next_read_next     = next_read_reg;
        window_start_next  = window_start_reg;
        window_active_next = window_active_reg;
        running            = 1'b0;
        done               = 1'b0;
        elapsed            = '0;

        since = in_data.now_us - next_read_reg;
        taken = !since[31];
        seed  = taken && pending_next;

        if (taken)
        begin
            next_read_next = in_data.now_us + {8'd0, read_period_reg};
            if (seed)
            begin
                pending_next       = 1'b0;
                window_active_next = 1'b1;
                window_start_next  = next_read_next;
            end
            elapsed = next_read_next - window_start_next;
            if (window_active_next)
            begin
                if (elapsed < {1'b0, cal_window_reg})
                begin
                    running = 1'b1;
                end
                else
                begin
                    done               = 1'b1;
                    window_active_next = 1'b0;
                end
            end
        end

        for (int a = 0; a < mmc_pkg::NUM_AXES; a++)
        begin
            field[a]    = taken ? raw[a] : 16'sd0;
            off_show[a] = 16'sd0;
        end

        for (int a = 0; a < AXIS_COUNT; a++)
        begin
            // a fresh request clears the offset and seeds min/max with the raw sample
            off_cur = seed ? 16'sd0  : offset_reg[a];
            lo_cur  = seed ? raw[a] : min_reg[a];
            hi_cur  = seed ? raw[a] : max_reg[a];

            if (taken && apply_offset_reg)
                field[a] = raw[a] - off_cur;

            offset_next[a] = taken ? off_cur : offset_reg[a];
            min_next[a]    = taken ? lo_cur  : min_reg[a];
            max_next[a]    = taken ? hi_cur  : max_reg[a];

            if (running)
            begin
                if (field[a] < lo_cur)
                    min_next[a] = field[a];
                if (field[a] > hi_cur)
                    max_next[a] = field[a];
            end

            // halve the sum, rounding toward zero
            sum = 17'(lo_cur) + 17'(hi_cur);
            if (done)
                offset_next[a] = 16'((sum + 17'(sum[16])) >>> 1);

            off_show[a] = offset_next[a];
        end

        out_next.read_taken  = taken;
        out_next.field_x     = field[0];
        out_next.field_y     = field[1];
        out_next.field_z     = field[2];
        out_next.cal_running = running;
        out_next.cal_done    = done;
        out_next.offset_x    = off_show[0];
        out_next.offset_y    = off_show[1];
        out_next.offset_z    = off_show[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_period_reg  <= mmc_pkg::READ_PERIOD_RESET;
            cal_window_reg   <= mmc_pkg::CAL_WINDOW_RESET;
            apply_offset_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mmc_pkg::CFG_READ_PERIOD:  read_period_reg  <= cfg_data[23:0];
                mmc_pkg::CFG_CAL_WINDOW:   cal_window_reg   <= cfg_data[30:0];
                mmc_pkg::CFG_APPLY_OFFSET: apply_offset_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_read_reg     <= '0;
            window_start_reg  <= '0;
            window_active_reg <= 1'b0;
            pending_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            for (int a = 0; a < AXIS_COUNT; a++)
                offset_reg[a] <= 16'sd0;
        end
        else
        begin
            if (in_fire)
            begin
                next_read_reg     <= next_read_next;
                window_start_reg  <= window_start_next;
                window_active_reg <= window_active_next;
                pending_reg       <= pending_next;
                for (int a = 0; a < AXIS_COUNT; a++)
                    offset_reg[a] <= offset_next[a];
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // min/max and the result word carry no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= out_next;
            for (int a = 0; a < AXIS_COUNT; a++)
            begin
                min_reg[a] <= min_next[a];
                max_reg[a] <= max_next[a];
            end
        end
    end

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted word produced no result");

    a_skip_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.read_taken) |-> (!out_data.cal_running && !out_data.cal_done))
        else $error("skipped sample flagged calibration activity");

    a_running_keeps_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.cal_running) |-> window_active_reg)
        else $error("window closed while result shows running");

    a_done_closes_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.cal_done) |-> (!window_active_reg && !out_data.cal_running))
        else $error("window still open after calibration done");

endmodule

`default_nettype wire

FILE: sim/magnetometer_minmax_calibrator_tb.sv
// Testbench for magnetometer_minmax_calibrator: directed and random words checked
// against a cycle-free predictor of read timing, windowed min/max and offset math.
// Depends on mmc_pkg and the magnetometer_minmax_calibrator RTL.
`default_nettype none

module magnetometer_minmax_calibrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mmc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 106;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_MASK, READY_SLOW} ready_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    mmc_pkg::in_t                    in_data;
    logic                            out_valid;
    logic                            out_ready;
    mmc_pkg::out_t                   out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mmc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mmc_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Predictor state and register mirror
    logic [23:0]        period_reg;
    logic [30:0]        window_reg;
    logic               apply_reg;
    logic [31:0]        next_read_us;
    logic [31:0]        window_start_us;
    logic               window_open;
    logic               cal_request;
    logic signed [15:0] hard_iron [3];
    logic signed [15:0] axis_lo [3];
    logic signed [15:0] axis_hi [3];

    mmc_pkg::out_t      expected_results [$];
    int                 mismatch_count;
    int                 burst_left;
    bit                 sender_steady;
    logic signed [15:0] field_center [3];
    ready_mode_t        ready_mode;
    int unsigned        ready_tick;

    magnetometer_minmax_calibrator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Work out the result of one accepted word and advance the calibrator state.
    function automatic mmc_pkg::out_t calibrate_step(input mmc_pkg::in_t w);
        mmc_pkg::out_t      r;
        logic signed [15:0] raw [3];
        logic signed [15:0] corr [3];
        logic [31:0]        lag;
        int                 sum;
        r = '0;
        raw[0] = w.sample_x;
        raw[1] = w.sample_y;
        raw[2] = w.sample_z;
        corr = '{16'sd0, 16'sd0, 16'sd0};
        if (w.start_cal)
            cal_request = 1'b1;
        lag = w.now_us - next_read_us;
        if (!lag[31])
        begin
            r.read_taken = 1'b1;
            next_read_us = w.now_us + {8'd0, period_reg};
            if (cal_request)
            begin
                cal_request = 1'b0;
                window_open = 1'b1;
                window_start_us = next_read_us;
                for (int a = 0; a < 3; a++)
                begin
                    hard_iron[a] = '0;
                    axis_lo[a] = raw[a];
                    axis_hi[a] = raw[a];
                end
            end
            for (int a = 0; a < 3; a++)
                corr[a] = apply_reg ? raw[a] - hard_iron[a] : raw[a];
            if (window_open)
            begin
                if (next_read_us - window_start_us < {1'b0, window_reg})
                begin
                    r.cal_running = 1'b1;
                    for (int a = 0; a < 3; a++)
                    begin
                        if (corr[a] < axis_lo[a])
                            axis_lo[a] = corr[a];
                        if (corr[a] > axis_hi[a])
                            axis_hi[a] = corr[a];
                    end
                end
                else
                begin
                    window_open = 1'b0;
                    r.cal_done = 1'b1;
                    for (int a = 0; a < 3; a++)
                    begin
                        // halve toward zero, as signed integer division does
                        sum = int'(axis_lo[a]) + int'(axis_hi[a]);
                        hard_iron[a] = 16'(sum / 2);
                    end
                end
            end
        end
        r.field_x = corr[0];
        r.field_y = corr[1];
        r.field_z = corr[2];
        r.offset_x = hard_iron[0];
        r.offset_y = hard_iron[1];
        r.offset_z = hard_iron[2];
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        mmc_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("read_taken", want.read_taken, out_data.read_taken);
                check_field("field_x", want.field_x, out_data.field_x);
                check_field("field_y", want.field_y, out_data.field_y);
                check_field("field_z", want.field_z, out_data.field_z);
                check_field("cal_running", want.cal_running, out_data.cal_running);
                check_field("cal_done", want.cal_done, out_data.cal_done);
                check_field("offset_x", want.offset_x, out_data.offset_x);
                check_field("offset_y", want.offset_y, out_data.offset_y);
                check_field("offset_z", want.offset_z, out_data.offset_z);
            end
        end
    end

    // Receiver stall pattern in one of four modes, redrawn at random as ready_tick advances.
    always @(negedge clk)
    begin
        ready_tick++;
        if (ready_tick % 256 == 0)
            ready_mode = ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
            READY_MASK:   out_ready <= 1'(13'b1011001110001 >> (ready_tick % 13));
            default:      out_ready <= (ready_tick % 8 == 0);
        endcase
    end

    function automatic mmc_pkg::in_t make_word(input logic [31:0] now,
                                               input logic signed [15:0] x,
                                               input logic signed [15:0] y,
                                               input logic signed [15:0] z,
                                               input logic start);
        mmc_pkg::in_t w;
        w.now_us = now;
        w.sample_x = x;
        w.sample_y = y;
        w.sample_z = z;
        w.start_cal = start;
        return w;
    endfunction

    function automatic logic signed [15:0] near_center(input logic signed [15:0] c);
        return c + 16'($urandom_range(0, 4000)) - 16'sd2000;
    endfunction

    // Mostly on-time reads with a spread around a hard-iron center; some early, some jumps.
    function automatic mmc_pkg::in_t random_word();
        mmc_pkg::in_t w;
        int unsigned  pick;
        int unsigned  span;
        pick = $urandom_range(0, 99);
        span = (period_reg > 1000) ? 1000 : period_reg;
        if (pick < 60)
            w.now_us = next_read_us + $urandom_range(0, 3);
        else if (pick < 78)
            w.now_us = next_read_us - $urandom_range(1, span);
        else if (pick < 92)
            w.now_us = next_read_us + $urandom_range(0, 2 * period_reg);
        else
            w.now_us = $urandom();
        if ($urandom_range(0, 1))
        begin
            w.sample_x = near_center(field_center[0]);
            w.sample_y = near_center(field_center[1]);
            w.sample_z = near_center(field_center[2]);
        end
        else
        begin
            w.sample_x = 16'($urandom());
            w.sample_y = 16'($urandom());
            w.sample_z = 16'($urandom());
        end
        if (!window_open && !cal_request)
            w.start_cal = ($urandom_range(0, 4) == 0);
        else
            w.start_cal = ($urandom_range(0, 39) == 0);
        return w;
    endfunction

    task automatic send_word(input mmc_pkg::in_t w);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (!sender_steady && idle > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (idle - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(calibrate_step(w));
    endtask

    // Hold the sender until every outstanding result word has been taken.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [mmc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        drain_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            mmc_pkg::CFG_READ_PERIOD:  period_reg = data[23:0];
            mmc_pkg::CFG_CAL_WINDOW:   window_reg = data[30:0];
            mmc_pkg::CFG_APPLY_OFFSET: apply_reg = data[0];
            default:                   ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reset defaults: first read at time zero, early read, time wrap, latched request.
    task automatic test_reset_defaults();
        send_word(make_word(32'd0, 16'sh7FFF, 16'sh8000, 16'sd0, 1'b1));
        send_word(make_word(32'd99999, 16'sd5, 16'sd5, 16'sd5, 1'b0));
        send_word(make_word(32'd100000, 16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b0));
        send_word(make_word(32'h7FFF_FFFF, 16'sd100, -16'sd100, 16'sd1, 1'b0));
        send_word(make_word(32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 16'sh5555, 1'b0));
        send_word(make_word(32'd5, 16'shAAAA, 16'sh5555, 16'sh0F0F, 1'b1));
        send_word(make_word(32'h0002_0000, 16'sh1234, -16'sh1234, 16'sh7FFF, 1'b0));
    endtask

    // Offset wrap on subtraction, halving of odd negative sums, raw pass-through.
    task automatic test_offset_extremes();
        write_reg(mmc_pkg::CFG_READ_PERIOD, 32'd1);
        write_reg(mmc_pkg::CFG_CAL_WINDOW, 32'd2);
        write_reg(mmc_pkg::CFG_APPLY_OFFSET, 32'd1);
        send_word(make_word(next_read_us, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b1));
        send_word(make_word(next_read_us, 16'sd32000, 16'sd30000, -16'sd30000, 1'b0));
        send_word(make_word(next_read_us, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_word(make_word(next_read_us, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0));
        send_word(make_word(next_read_us - 1, 16'sd1, 16'sd2, 16'sd3, 1'b1));
        send_word(make_word(next_read_us, -16'sd3, -16'sd1, 16'sd1, 1'b0));
        send_word(make_word(next_read_us, -16'sd3, -16'sd2, 16'sd2, 1'b0));
        send_word(make_word(next_read_us, 16'sd7, 16'sd7, 16'sd7, 1'b0));
        send_word(make_word(next_read_us, 16'sh8000, 16'sh7FFF, 16'sd0, 1'b0));
        write_reg(mmc_pkg::CFG_APPLY_OFFSET, 32'd0);
        send_word(make_word(next_read_us, 16'sh8000, 16'sh7FFF, -16'sd1, 1'b0));
        send_word(make_word(next_read_us + 1, 16'sd9, -16'sd9, 16'sd0, 1'b0));
    endtask

    task automatic test_random_phases();
        logic [23:0] period;
        logic [30:0] window;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            period = 24'($urandom_range(1, 40));
            window = 31'(period * $urandom_range(2, 12));
            case (phase)
                0, 6:
                begin
                    write_reg(mmc_pkg::CFG_READ_PERIOD, 32'(period));
                    write_reg(mmc_pkg::CFG_CAL_WINDOW, 32'(window));
                    write_reg(mmc_pkg::CFG_APPLY_OFFSET, 32'd1);
                end
                1:
                begin
                    write_reg(mmc_pkg::CFG_READ_PERIOD, 32'(period));
                    write_reg(mmc_pkg::CFG_CAL_WINDOW, 32'(window));
                    write_reg(mmc_pkg::CFG_APPLY_OFFSET, 32'd0);
                end
                2:
                begin
                    write_reg(mmc_pkg::CFG_READ_PERIOD, 32'd1);
                    write_reg(mmc_pkg::CFG_CAL_WINDOW, 32'd1);
                    write_reg(mmc_pkg::CFG_APPLY_OFFSET, 32'd1);
                end
                3:
                begin
                    write_reg(mmc_pkg::CFG_READ_PERIOD, 32'h00FF_FFFF);
                    write_reg(mmc_pkg::CFG_CAL_WINDOW, 32'h7FFF_FFFF);
                end
                4:
                begin
                    // full-width data; only the low register bits count
                    write_reg(mmc_pkg::CFG_READ_PERIOD, $urandom() | 32'h1);
                    write_reg(mmc_pkg::CFG_CAL_WINDOW, $urandom() | 32'h1);
                    write_reg(mmc_pkg::CFG_APPLY_OFFSET, $urandom());
                    write_reg(CFG_UNUSED, $urandom());
                end
                default:
                begin
                    write_reg(mmc_pkg::CFG_READ_PERIOD, $urandom_range(1, 200));
                    write_reg(mmc_pkg::CFG_CAL_WINDOW, $urandom_range(1, 3000));
                    write_reg(mmc_pkg::CFG_APPLY_OFFSET, $urandom_range(0, 1));
                end
            endcase
            for (int a = 0; a < 3; a++)
                field_center[a] = 16'($urandom());
            sender_steady = (phase == 2 || phase == 5);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n == WORDS_PER_PHASE / 2)
                    drain_results();
                send_word(random_word());
            end
        end
        sender_steady = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mmc_pkg::CFG_READ_PERIOD;
        cfg_data = '0;
        period_reg = mmc_pkg::READ_PERIOD_RESET;
        window_reg = mmc_pkg::CAL_WINDOW_RESET;
        apply_reg = 1'b1;
        next_read_us = '0;
        window_start_us = '0;
        window_open = 1'b0;
        cal_request = 1'b0;
        hard_iron = '{16'sd0, 16'sd0, 16'sd0};
        axis_lo = '{16'sd0, 16'sd0, 16'sd0};
        axis_hi = '{16'sd0, 16'sd0, 16'sd0};
        mismatch_count = 0;
        burst_left = 0;
        sender_steady = 1'b0;
        ready_mode = READY_ALWAYS;
        ready_tick = 0;
        field_center = '{16'sd0, 16'sd0, 16'sd0};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_offset_extremes();
        test_random_phases();

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
